// ===== rtl/rsmp_pkg.sv =====
package rsmp_pkg;

  localparam int DEF_RES_DEPTH  = 256;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed field widths of the item ports
  localparam int DATUM_W = 32;
  localparam int RAND_W  = 16;
  localparam int SLOT_W  = 8;
  localparam int SIZE_W  = 9;
  localparam int SEEN_W  = 32;

  localparam logic [SEEN_W-1:0] SEEN_TOP = '1;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // decision for one offered item
  typedef struct packed {
    logic              stored;
    logic              fill_room;
    logic [SIZE_W-1:0] wslot;
  } offer_t;

endpackage

// ===== rtl/rsmp_ram.sv =====
module rsmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rsmp_offer.sv =====
module rsmp_offer import rsmp_pkg::*; (
  input  logic [SIZE_W-1:0] k_act,
  input  logic [SIZE_W-1:0] fill_level,
  input  logic [SEEN_W-1:0] seen_inc,
  input  logic [RAND_W-1:0] rand_accept,
  input  logic [RAND_W-1:0] rand_slot,
  output offer_t            ofr
);

  logic [RAND_W+SEEN_W-1:0] prod_acc;
  logic [RAND_W+SEEN_W-1:0] limit;
  logic [RAND_W+SIZE_W-1:0] prod_slot;
  logic                     keep;

  // keep with chance k / seen: rand * seen < k * 2^16
  assign prod_acc  = (RAND_W+SEEN_W)'(rand_accept) * (RAND_W+SEEN_W)'(seen_inc);
  assign limit     = {{(SEEN_W-SIZE_W){1'b0}}, k_act, {RAND_W{1'b0}}};
  assign keep      = prod_acc < limit;
  // replaced slot is the top bits of rand * k, always below k
  assign prod_slot = (RAND_W+SIZE_W)'(rand_slot) * (RAND_W+SIZE_W)'(k_act);

  always_comb begin
    ofr.fill_room = fill_level < k_act;
    ofr.stored    = ofr.fill_room || keep;
    ofr.wslot     = ofr.fill_room ? fill_level : prod_slot[RAND_W+SIZE_W-1:RAND_W];
  end

endmodule

// ===== rtl/reservoir_sampler_core.sv =====
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------------
// in       | in_valid / in_stall    | operation, datum, rand_accept, rand_slot, slot
// out      | out_valid / out_stall  | stored, written_slot, read_data, read_valid,
//          |                        | seen_count, fill_count
// cfg      | cfg_valid / cfg_ready  | cfg_data (reservoir_size)
//
// one item per cycle sustained while out_stall is low; an item's result passes through
// the decision stage, where the slot memory's registered read lands, and then the
// output register
// offers decide and write the slot memory in the accept cycle, so a later read sees it
// rst is synchronous: counters and fill level clear, size returns to its default; slot memory is not cleared
// in_stall rises only when both the decision stage and the output register hold items
module reservoir_sampler_core import rsmp_pkg::*; #(
  parameter int RES_DEPTH  = DEF_RES_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [DATUM_W-1:0]  datum,
  input  logic [RAND_W-1:0]   rand_accept,
  input  logic [RAND_W-1:0]   rand_slot,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                stored,
  output logic [SLOT_W-1:0]   written_slot,
  output logic [DATUM_W-1:0]  read_data,
  output logic                read_valid,
  output logic [SEEN_W-1:0]   seen_count,
  output logic [SIZE_W-1:0]   fill_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_data
);

  localparam int AW    = $clog2(RES_DEPTH);
  localparam int MEM_W = (DATA_WIDTH < DATUM_W) ? DATA_WIDTH : DATUM_W;
  localparam logic [SIZE_W-1:0] K_RESET = SIZE_W'((RES_DEPTH < 256) ? RES_DEPTH : 256);
  localparam logic [SIZE_W-1:0] K_CAP   = SIZE_W'((RES_DEPTH < 511) ? RES_DEPTH : 511);

  logic [SIZE_W-1:0] k_act;
  logic [SIZE_W-1:0] k_cfg;
  logic [SEEN_W-1:0] items_seen;
  logic [SEEN_W-1:0] seen_inc;
  logic [SIZE_W-1:0] fill_level;
  logic [SIZE_W-1:0] fill_next;

  logic              in_acc;
  logic              is_offer;
  offer_t            ofr;
  logic              out_adv;
  logic              s1_adv;

  logic              s1_v;
  logic              s1_read;
  logic              s1_stored;
  logic [SLOT_W-1:0] s1_wslot;
  logic              s1_rvalid;
  logic [SEEN_W-1:0] s1_seen;
  logic [SIZE_W-1:0] s1_fill;

  logic [16:0]       wslot_ext;
  logic [16:0]       slot_ext;
  logic              ram_we;
  logic              ram_re;
  logic [MEM_W-1:0]  ram_rdata;

  // size register holds the clamped size
  assign cfg_ready = 1'b1;
  always_comb begin
    if (cfg_data == '0) begin
      k_cfg = SIZE_W'(1);
    end else if ({8'b0, cfg_data} > 17'(RES_DEPTH)) begin
      k_cfg = K_CAP;
    end else begin
      k_cfg = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_act <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_act <= k_cfg;
    end
  end

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = s1_v && out_adv;
  assign in_stall = s1_v && !out_adv;
  assign in_acc   = in_valid && !in_stall;
  assign is_offer = (op_t'(operation) == OP_OFFER);

  rsmp_offer u_offer (
    .k_act       (k_act),
    .fill_level  (fill_level),
    .seen_inc    (seen_inc),
    .rand_accept (rand_accept),
    .rand_slot   (rand_slot),
    .ofr         (ofr)
  );

  assign fill_next = fill_level + SIZE_W'(ofr.fill_room);

  // seen_inc runs one ahead so the accept test needs no adder in front of it
  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen <= '0;
      seen_inc   <= SEEN_W'(1);
      fill_level <= '0;
    end else if (in_acc && is_offer) begin
      items_seen <= seen_inc;
      seen_inc   <= (seen_inc == SEEN_TOP) ? SEEN_TOP : seen_inc + SEEN_W'(1);
      fill_level <= fill_next;
    end
  end

  // slot memory: written at accept, read data lands with the decision stage
  assign wslot_ext = {8'b0, ofr.wslot};
  assign slot_ext  = {9'b0, slot};
  assign ram_we    = in_acc && is_offer && ofr.stored;
  assign ram_re    = in_acc && !is_offer;

  rsmp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (RES_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot_ext[AW-1:0]),
    .wdata (datum[MEM_W-1:0]),
    .re    (ram_re),
    .raddr (slot_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_acc) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_read   <= !is_offer;
      s1_stored <= is_offer && ofr.stored;
      s1_wslot  <= (is_offer && ofr.stored) ? ofr.wslot[SLOT_W-1:0] : '0;
      s1_rvalid <= !is_offer && ({1'b0, slot} < fill_level);
      s1_seen   <= is_offer ? seen_inc : items_seen;
      s1_fill   <= is_offer ? fill_next : fill_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      stored       <= s1_stored;
      written_slot <= s1_wslot;
      read_data    <= (s1_read && s1_rvalid) ? DATUM_W'(ram_rdata) : '0;
      read_valid   <= s1_read && s1_rvalid;
      seen_count   <= s1_seen;
      fill_count   <= s1_fill;
    end
  end

  a_fill_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill_level >= $past(fill_level))
    else $error("fill level decreased");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill_level <= K_CAP)
    else $error("fill level above reservoir depth");

  a_seen_ahead: assert property (@(posedge clk) disable iff (rst)
    items_seen != SEEN_TOP |-> seen_inc == items_seen + SEEN_W'(1))
    else $error("look-ahead count out of step");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ofr.wslot < k_act)
    else $error("write slot beyond active size");

endmodule
